// ----- hdl/hfsp_pkg.sv -----
// hfsp_pkg: types, codes and helper functions of the hex float string parser
// no dependencies; used by hfsp_parse, hfsp_scale, the top level and the testbench
package hfsp_pkg;

  localparam int SIG_W = 53;  // double significand with hidden bit
  localparam int LEN_W = 11;  // bit length of the accumulated integer
  localparam int ESC_W = 24;  // signed binary scale and biased exponent
  localparam logic [LEN_W-1:0] LEN_MAX = 11'd1024;

  typedef enum logic [3:0] {
    PH_LEAD, PH_ZERO, PH_X, PH_INT, PH_FRAC,
    PH_ESIGN, PH_EDIG1, PH_EDIGS, PH_TRAIL, PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HAS_N   = 2'd1,
    ST_NOT_HEX = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  // mantissa: value is m when len <= 53, else m * 2^(len-53)
  typedef struct packed {
    logic             inf;
    logic [LEN_W-1:0] len;
    logic [SIG_W-1:0] m;
  } mant_t;

  // parsed string handed to the scaling stages
  typedef struct packed {
    logic             sign;
    mant_t            mant;
    logic [ESC_W-1:0] scale;
    status_t          status;
  } snap_t;

  function automatic logic is_ws(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // hex digit value in [3:0], valid in [4]
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= "0" && c <= "9") begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= "a" && c <= "f") begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if (c >= "A" && c <= "F") begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // value * 16 + d, rounded to nearest even
  function automatic mant_t mant_step(mant_t cur, logic [3:0] d);
    mant_t       r;
    logic [56:0] w;
    logic [53:0] q;
    logic        half;
    logic        sticky;
    r = cur;
    w = {cur.m, 4'b0000} | {53'd0, d};
    q = '0;
    half = 1'b0;
    sticky = 1'b0;
    if (!cur.inf) begin
      if (cur.len == '0) begin
        r.m = {49'd0, d};
        if (d[3]) r.len = 11'd4;
        else if (d[2]) r.len = 11'd3;
        else if (d[1]) r.len = 11'd2;
        else if (d[0]) r.len = 11'd1;
        else r.len = 11'd0;
      end else if (cur.len <= 11'd49) begin
        r.m = w[52:0];
        r.len = cur.len + 11'd4;
      end else if (cur.len <= 11'd53) begin
        case (cur.len)
          11'd50: begin
            q = {1'b0, w[53:1]};
            half = w[0];
          end
          11'd51: begin
            q = {1'b0, w[54:2]};
            half = w[1];
            sticky = w[0];
          end
          11'd52: begin
            q = {1'b0, w[55:3]};
            half = w[2];
            sticky = |w[1:0];
          end
          default: begin
            q = {1'b0, w[56:4]};
            half = w[3];
            sticky = |w[2:0];
          end
        endcase
        if (half && (sticky || q[0])) q = q + 54'd1;
        if (q[53]) begin
          r.m = q[53:1];
          r.len = cur.len + 11'd5;
        end else begin
          r.m = q[52:0];
          r.len = cur.len + 11'd4;
        end
      end else begin
        r.len = cur.len + 11'd4;
      end
      if (r.len > LEN_MAX) r.inf = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- hdl/hfsp_in_if.sv -----
// hfsp_in_if: character channel of the hex float string parser
// depends on nothing
interface hfsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

// ----- hdl/hfsp_out_if.sv -----
// hfsp_out_if: result channel of the hex float string parser
// depends on nothing
interface hfsp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic [1:0]  status;
  modport source (output valid, value_bits, status, input ready);
  modport sink (input valid, value_bits, status, output ready);
endinterface

// ----- hdl/hfsp_parse.sv -----
// hfsp_parse: input register, syntax state machine and mantissa accumulation
// depends on hfsp_pkg
module hfsp_parse #(
  parameter int EXP_SATURATE = 65535
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [7:0]     ch,
  input  logic           last,
  output logic           snap_valid,
  output hfsp_pkg::snap_t snap
);
  localparam int EW = $clog2(EXP_SATURATE + 1);

  logic                v1;
  logic [7:0]          ch_r;
  logic                last_r;

  hfsp_pkg::phase_t    phase, phase_next;
  hfsp_pkg::mant_t     mant, mant_next;
  logic                negative, negative_next;
  logic                int_seen, int_seen_next;
  logic [15:0]         frac_cnt, frac_cnt_next;
  logic [EW-1:0]       exp_acc, exp_acc_next;
  logic                exp_neg, exp_neg_next;
  logic                saw_n, saw_n_next;
  logic                saw_x, saw_x_next;

  logic [4:0]          hv;
  logic                any_cur, any_next, ok;
  logic [EW+3:0]       exp_sum;
  logic [hfsp_pkg::ESC_W-1:0] exp_mag, scale_calc;
  hfsp_pkg::snap_t     snap_next;

  always_comb begin
    hv = hfsp_pkg::hex_val(ch_r);
    any_cur = int_seen || frac_cnt != 16'd0;
    exp_sum = ((EW+4)'(exp_acc) << 3) + ((EW+4)'(exp_acc) << 1) + (EW+4)'(ch_r - 8'h30);
    phase_next = phase;
    mant_next = mant;
    negative_next = negative;
    int_seen_next = int_seen;
    frac_cnt_next = frac_cnt;
    exp_acc_next = exp_acc;
    exp_neg_next = exp_neg;
    saw_n_next = saw_n || ch_r == "n" || ch_r == "N";
    saw_x_next = saw_x || ch_r == "x" || ch_r == "X";
    case (phase)
      hfsp_pkg::PH_LEAD: begin
        if (!hfsp_pkg::is_ws(ch_r)) begin
          if (ch_r == "-") begin
            negative_next = 1'b1;
            phase_next = hfsp_pkg::PH_ZERO;
          end else if (ch_r == "+") phase_next = hfsp_pkg::PH_ZERO;
          else if (ch_r == "0") phase_next = hfsp_pkg::PH_X;
          else phase_next = hfsp_pkg::PH_ERR;
        end
      end
      hfsp_pkg::PH_ZERO: begin
        phase_next = (ch_r == "0") ? hfsp_pkg::PH_X : hfsp_pkg::PH_ERR;
      end
      hfsp_pkg::PH_X: begin
        phase_next = (ch_r == "x" || ch_r == "X") ? hfsp_pkg::PH_INT : hfsp_pkg::PH_ERR;
      end
      hfsp_pkg::PH_INT, hfsp_pkg::PH_FRAC: begin
        if (hv[4]) begin
          mant_next = hfsp_pkg::mant_step(mant, hv[3:0]);
          if (phase == hfsp_pkg::PH_INT) int_seen_next = 1'b1;
          else if (frac_cnt != 16'hFFFF) frac_cnt_next = frac_cnt + 16'd1;
        end else if (ch_r == "." && phase == hfsp_pkg::PH_INT) begin
          phase_next = hfsp_pkg::PH_FRAC;
        end else if (ch_r == "p" || ch_r == "P") begin
          phase_next = any_cur ? hfsp_pkg::PH_ESIGN : hfsp_pkg::PH_ERR;
        end else if (hfsp_pkg::is_ws(ch_r)) begin
          phase_next = any_cur ? hfsp_pkg::PH_TRAIL : hfsp_pkg::PH_ERR;
        end else phase_next = hfsp_pkg::PH_ERR;
      end
      hfsp_pkg::PH_ESIGN: begin
        if (ch_r == "-") begin
          exp_neg_next = 1'b1;
          phase_next = hfsp_pkg::PH_EDIG1;
        end else if (ch_r == "+") phase_next = hfsp_pkg::PH_EDIG1;
        else if (hfsp_pkg::is_dec(ch_r)) begin
          exp_acc_next = (exp_sum > (EW+4)'(EXP_SATURATE)) ? EW'(EXP_SATURATE)
                                                           : exp_sum[EW-1:0];
          phase_next = hfsp_pkg::PH_EDIGS;
        end else phase_next = hfsp_pkg::PH_ERR;
      end
      hfsp_pkg::PH_EDIG1, hfsp_pkg::PH_EDIGS: begin
        if (hfsp_pkg::is_dec(ch_r)) begin
          exp_acc_next = (exp_sum > (EW+4)'(EXP_SATURATE)) ? EW'(EXP_SATURATE)
                                                           : exp_sum[EW-1:0];
          phase_next = hfsp_pkg::PH_EDIGS;
        end else if (phase == hfsp_pkg::PH_EDIGS && hfsp_pkg::is_ws(ch_r)) begin
          phase_next = hfsp_pkg::PH_TRAIL;
        end else phase_next = hfsp_pkg::PH_ERR;
      end
      hfsp_pkg::PH_TRAIL: begin
        if (!hfsp_pkg::is_ws(ch_r)) phase_next = hfsp_pkg::PH_ERR;
      end
      default: phase_next = hfsp_pkg::PH_ERR;
    endcase

    // result of the finished string
    any_next = int_seen_next || frac_cnt_next != 16'd0;
    ok = phase_next == hfsp_pkg::PH_EDIGS || phase_next == hfsp_pkg::PH_TRAIL ||
         ((phase_next == hfsp_pkg::PH_INT || phase_next == hfsp_pkg::PH_FRAC) && any_next);
    exp_mag = hfsp_pkg::ESC_W'(exp_acc_next);
    scale_calc = (exp_neg_next ? -exp_mag : exp_mag) -
                 hfsp_pkg::ESC_W'({frac_cnt_next, 2'b00});
    snap_next.sign = negative_next;
    snap_next.mant = mant_next;
    snap_next.scale = scale_calc;
    if (saw_n_next) snap_next.status = hfsp_pkg::ST_HAS_N;
    else if (!saw_x_next) snap_next.status = hfsp_pkg::ST_NOT_HEX;
    else if (!ok) snap_next.status = hfsp_pkg::ST_BAD;
    else snap_next.status = hfsp_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      snap_valid <= 1'b0;
      phase <= hfsp_pkg::PH_LEAD;
      mant <= '0;
      negative <= 1'b0;
      int_seen <= 1'b0;
      frac_cnt <= '0;
      exp_acc <= '0;
      exp_neg <= 1'b0;
      saw_n <= 1'b0;
      saw_x <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      snap_valid <= v1 && last_r;
      if (v1) begin
        if (last_r) begin
          phase <= hfsp_pkg::PH_LEAD;
          mant <= '0;
          negative <= 1'b0;
          int_seen <= 1'b0;
          frac_cnt <= '0;
          exp_acc <= '0;
          exp_neg <= 1'b0;
          saw_n <= 1'b0;
          saw_x <= 1'b0;
        end else begin
          phase <= phase_next;
          mant <= mant_next;
          negative <= negative_next;
          int_seen <= int_seen_next;
          frac_cnt <= frac_cnt_next;
          exp_acc <= exp_acc_next;
          exp_neg <= exp_neg_next;
          saw_n <= saw_n_next;
          saw_x <= saw_x_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_r <= ch;
      last_r <= last;
      snap <= snap_next;
    end
  end

endmodule

// ----- hdl/hfsp_scale.sv -----
// hfsp_scale: normalize stage and ldexp rounding stage with the result register
// depends on hfsp_pkg
module hfsp_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            snap_valid,
  input  hfsp_pkg::snap_t snap,
  output logic            res_valid,
  output logic [63:0]     value_bits,
  output logic [1:0]      status
);
  // normalize stage registers
  logic                       v3;
  logic                       sign3, inf3, zero3;
  logic [52:0]                mn3;
  logic signed [hfsp_pkg::ESC_W-1:0] rb3;
  hfsp_pkg::status_t          st3;

  logic [52:0]                mn_calc;
  logic [5:0]                 lsh;
  logic signed [hfsp_pkg::ESC_W-1:0] rb_calc, sh;
  logic [5:0]                 sh6;
  logic [52:0]                q, rem_mask;
  logic                       half, sticky;
  logic [63:0]                bits_calc;

  always_comb begin
    lsh = 6'd53 - snap.mant.len[5:0];
    mn_calc = (snap.mant.len >= 11'd53) ? snap.mant.m : (snap.mant.m << lsh);
    // biased exponent of the leading bit
    rb_calc = $signed(hfsp_pkg::ESC_W'(snap.mant.len)) + 24'sd1022 + $signed(snap.scale);
  end

  always_comb begin
    sh = 24'sd1 - rb3;
    sh6 = sh[5:0];
    q = mn3 >> sh6;
    rem_mask = (53'd1 << (sh6 - 6'd1)) - 53'd1;
    half = mn3[sh6 - 6'd1];
    sticky = |(mn3 & rem_mask);
    bits_calc = '0;
    if (st3 != hfsp_pkg::ST_OK) bits_calc = '0;
    else if (inf3) bits_calc = {sign3, 11'h7FF, 52'd0};
    else if (zero3) bits_calc = {sign3, 63'd0};
    else if (rb3 >= 24'sd2047) bits_calc = {sign3, 11'h7FF, 52'd0};
    else if (rb3 >= 24'sd1) bits_calc = {sign3, rb3[10:0], mn3[51:0]};
    else if (sh >= 24'sd54) bits_calc = {sign3, 63'd0};
    else begin
      if (half && (sticky || q[0])) q = q + 53'd1;
      bits_calc = {sign3, 10'd0, q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v3 <= snap_valid;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign3 <= snap.sign;
      inf3 <= snap.mant.inf;
      zero3 <= snap.mant.len == '0;
      mn3 <= mn_calc;
      rb3 <= rb_calc;
      st3 <= snap.status;
      value_bits <= bits_calc;
      status <= st3;
    end
  end

endmodule

// ----- hdl/hex_float_string_parser.sv -----
// hex_float_string_parser: top level of the hexadecimal float string parser
// depends on hfsp_pkg, hfsp_in_if, hfsp_out_if, hfsp_parse, hfsp_scale
//
// usage
//   in_ch carries one character per transaction (ch, last); last marks the
//   final character of a string. out_ch carries one transaction per string:
//   the double bit pattern in value_bits and status (0 ok, 1 has n or N,
//   2 not hexadecimal, 3 malformed); value_bits is zero unless ok.
// throughput
//   one character per cycle while out_ch takes results; a new string may start right after
//   the last character of the previous one.
// pipeline
//   the input register loads at the transaction of the last character, then
//   the parse snapshot, normalize register and result register load in
//   that order, and out_ch.valid rises with the result register.
// reset
//   rst (synchronous) empties the pipeline and returns the parser to the
//   leading whitespace state.
// stall
//   while out_ch holds a result that is not taken, the whole pipeline holds
//   and in_ch.ready is low; a taken result frees the pipeline in that cycle.
module hex_float_string_parser #(
  parameter int EXP_SATURATE = 65535
) (
  input logic       clk,
  input logic       rst,
  hfsp_in_if.sink   in_ch,
  hfsp_out_if.source out_ch
);
  logic            en;
  logic            snap_valid;
  hfsp_pkg::snap_t snap;

  // pipeline advances when the result register is empty or being drained
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  hfsp_parse #(
    .EXP_SATURATE(EXP_SATURATE)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_ch.valid),
    .ch         (in_ch.ch),
    .last       (in_ch.last),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  hfsp_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .snap_valid (snap_valid),
    .snap       (snap),
    .res_valid  (out_ch.valid),
    .value_bits (out_ch.value_bits),
    .status     (out_ch.status)
  );

endmodule

// ----- verif/tb_hex_float_string_parser.sv -----
// tb_hex_float_string_parser: self-checking testbench of the hex float string parser
// depends on hfsp_pkg, hfsp_in_if, hfsp_out_if and hex_float_string_parser
`timescale 1ns / 100ps

module tb_hex_float_string_parser;

  localparam int EXP_SAT = 65535;
  localparam longint CYCLE_LIMIT = 2000000;

  // expected parse of one string
  typedef struct {
    logic [63:0]       bits;
    hfsp_pkg::status_t status;
  } parse_result_t;

  // string predictor and store of expected parse results
  class parse_scoreboard;
    hfsp_pkg::phase_t ph;
    real           mant;
    bit            neg;
    bit            int_seen;
    int            frac_cnt;
    longint        exp_acc;
    bit            exp_neg;
    bit            has_n;
    bit            has_x;
    parse_result_t pending[$];
    int            errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph = hfsp_pkg::PH_LEAD;
      mant = 0.0;
      neg = 0;
      int_seen = 0;
      frac_cnt = 0;
      exp_acc = 0;
      exp_neg = 0;
      has_n = 0;
      has_x = 0;
    endfunction

    function bit ws(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit dec(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function int hexv(logic [7:0] c);
      if (dec(c)) return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function void add_exp(logic [7:0] c);
      exp_acc = exp_acc * 10 + longint'(c) - 48;
      if (exp_acc > EXP_SAT) exp_acc = EXP_SAT;
    endfunction

    // b * 2^e rounded once to nearest even, subnormals included
    function logic [63:0] scale_pow2(logic [63:0] b, longint e);
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      longint      bexp;
      longint      rb;
      longint      sh;
      bexp = longint'(b[62:52]);
      m = {12'd0, b[51:0]};
      if (bexp == 2047) return b;
      if (bexp == 0 && m == 0) return b;
      if (bexp == 0) begin
        bexp = 1;
        while (!m[52]) begin
          m = m << 1;
          bexp--;
        end
      end else begin
        m[52] = 1'b1;
      end
      rb = bexp + e;
      if (rb >= 2047) return {b[63], 11'h7FF, 52'd0};
      if (rb >= 1) return {b[63], rb[10:0], m[51:0]};
      sh = 1 - rb;
      if (sh >= 54) return {b[63], 63'd0};
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return {b[63], 63'd0} | q;
    endfunction

    // one accepted character transaction
    function void note_char(logic [7:0] c, bit fin);
      int            h;
      bit            any;
      bit            ok;
      parse_result_t r;
      longint        e;
      logic [63:0]   mb;
      h = hexv(c);
      any = int_seen || frac_cnt != 0;
      if (c == "n" || c == "N") has_n = 1;
      if (c == "x" || c == "X") has_x = 1;
      case (ph)
        hfsp_pkg::PH_LEAD: begin
          if (!ws(c)) begin
            if (c == "-") begin
              neg = 1;
              ph = hfsp_pkg::PH_ZERO;
            end else if (c == "+") ph = hfsp_pkg::PH_ZERO;
            else if (c == "0") ph = hfsp_pkg::PH_X;
            else ph = hfsp_pkg::PH_ERR;
          end
        end
        hfsp_pkg::PH_ZERO: ph = (c == "0") ? hfsp_pkg::PH_X : hfsp_pkg::PH_ERR;
        hfsp_pkg::PH_X: ph = (c == "x" || c == "X") ? hfsp_pkg::PH_INT : hfsp_pkg::PH_ERR;
        hfsp_pkg::PH_INT, hfsp_pkg::PH_FRAC: begin
          if (h >= 0) begin
            mant = mant * 16.0 + real'(h);
            if (ph == hfsp_pkg::PH_INT) int_seen = 1;
            else if (frac_cnt < 65535) frac_cnt++;
          end else if (c == "." && ph == hfsp_pkg::PH_INT) ph = hfsp_pkg::PH_FRAC;
          else if (c == "p" || c == "P") ph = any ? hfsp_pkg::PH_ESIGN : hfsp_pkg::PH_ERR;
          else if (ws(c)) ph = any ? hfsp_pkg::PH_TRAIL : hfsp_pkg::PH_ERR;
          else ph = hfsp_pkg::PH_ERR;
        end
        hfsp_pkg::PH_ESIGN: begin
          if (c == "-") begin
            exp_neg = 1;
            ph = hfsp_pkg::PH_EDIG1;
          end else if (c == "+") ph = hfsp_pkg::PH_EDIG1;
          else if (dec(c)) begin
            add_exp(c);
            ph = hfsp_pkg::PH_EDIGS;
          end else ph = hfsp_pkg::PH_ERR;
        end
        hfsp_pkg::PH_EDIG1, hfsp_pkg::PH_EDIGS: begin
          if (dec(c)) begin
            add_exp(c);
            ph = hfsp_pkg::PH_EDIGS;
          end else if (ph == hfsp_pkg::PH_EDIGS && ws(c)) ph = hfsp_pkg::PH_TRAIL;
          else ph = hfsp_pkg::PH_ERR;
        end
        hfsp_pkg::PH_TRAIL: if (!ws(c)) ph = hfsp_pkg::PH_ERR;
        default: ph = hfsp_pkg::PH_ERR;
      endcase
      if (!fin) return;
      any = int_seen || frac_cnt != 0;
      ok = ph == hfsp_pkg::PH_EDIGS || ph == hfsp_pkg::PH_TRAIL ||
           ((ph == hfsp_pkg::PH_INT || ph == hfsp_pkg::PH_FRAC) && any);
      r.bits = '0;
      if (has_n) r.status = hfsp_pkg::ST_HAS_N;
      else if (!has_x) r.status = hfsp_pkg::ST_NOT_HEX;
      else if (!ok) r.status = hfsp_pkg::ST_BAD;
      else begin
        e = exp_neg ? -exp_acc : exp_acc;
        e = e - 4 * longint'(frac_cnt);
        mb = $realtobits(mant);
        mb[63] = neg;
        r.bits = scale_pow2(mb, e);
        r.status = hfsp_pkg::ST_OK;
      end
      pending.push_back(r);
      clear();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    // one accepted result transaction
    task check_result(logic [63:0] bits, logic [1:0] status);
      parse_result_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result bits=%h status=%0d", bits, status));
        return;
      end
      r = pending.pop_front();
      if (status !== r.status)
        report($sformatf("status %0d, expected %0d", status, r.status));
      if (bits !== r.bits)
        report($sformatf("value_bits %h, expected %h", bits, r.bits));
    endtask
  endclass

  logic clk;
  logic rst;
  hfsp_in_if  in_ch ();
  hfsp_out_if out_ch ();

  parse_scoreboard sb;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_cycles;
  longint cycles;

  hex_float_string_parser #(.EXP_SATURATE(EXP_SAT)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // overall timeout, counted in cycles
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_hex_float_string_parser failed");
      $finish;
    end
  end

  // receiver side: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (rst) out_ch.ready = 1'b0;
    else if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor: every accepted result transaction gets checked
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.value_bits, out_ch.status);
  end

  // one character transaction; valid stays high into the next one unless idling
  task automatic send_char(logic [7:0] c, bit fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.ch = c;
    in_ch.last = fin;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_char(c, fin);
    @(negedge clk);
  endtask

  task automatic send_bytes(ref byte unsigned s[$]);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(string t);
    byte unsigned s[$];
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_bytes(s);
  endtask

  function automatic byte unsigned rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(48 + v);
    return $urandom_range(0, 1) ? 8'(87 + v) : 8'(55 + v);
  endfunction

  function automatic byte unsigned rand_ws();
    int v;
    v = $urandom_range(0, 6);
    return (v == 6) ? 8'h20 : 8'(9 + (v % 5));
  endfunction

  // mostly well-formed strings with random content, the rest noise or broken
  task automatic make_string(ref byte unsigned s[$]);
    int    kind;
    int    ni;
    int    nf;
    int    ev;
    string es;
    s.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 12)) s.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) s.push_back(rand_ws());
    case ($urandom_range(0, 2))
      0: s.push_back("-");
      1: s.push_back("+");
      default: ;
    endcase
    s.push_back("0");
    s.push_back($urandom_range(0, 1) ? "x" : "X");
    ni = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 300) : $urandom_range(0, 14);
    nf = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 14);
    if (ni + nf == 0) ni = 1;
    repeat (ni) s.push_back(rand_hex());
    if (nf > 0 || $urandom_range(0, 3) == 0) s.push_back(".");
    repeat (nf) s.push_back(rand_hex());
    if ($urandom_range(0, 9) < 6) begin
      s.push_back($urandom_range(0, 1) ? "p" : "P");
      case ($urandom_range(0, 2))
        0: s.push_back("-");
        1: s.push_back("+");
        default: ;
      endcase
      ev = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999999) : $urandom_range(0, 1150);
      es = $sformatf("%0d", ev);
      if ($urandom_range(0, 7) == 0) s.push_back("0");
      for (int i = 0; i < es.len(); i++) s.push_back(es[i]);
    end
    repeat ($urandom_range(0, 2)) s.push_back(rand_ws());
    // broken variants: a random byte swapped in, or the tail cut off
    if (kind < 30) begin
      if ($urandom_range(0, 1))
        s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      else repeat ($urandom_range(1, s.size() - 1)) void'(s.pop_back());
    end
  endtask

  task automatic run_random(int n_chars);
    byte unsigned s[$];
    int           sent;
    sent = 0;
    while (sent < n_chars) begin
      make_string(s);
      send_bytes(s);
      sent += s.size();
    end
  endtask

  // sender pause: nothing offered until every expected result is back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    byte unsigned s[$];
    sb = new();
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.ch = 8'd0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // directed strings: sign, zero, rounding, subnormals, overflow, errors
    send_text("0x0");
    send_text("-0x0");
    send_text("0x0p99999");
    send_text(" \t+0X1.8P+3 \n");
    send_text("0xFFFFFFFFFFFFFFFFFp0");
    send_text("0x1fffffffffffff8");
    send_text("0x1p-1074");
    send_text("0x1p-1075");
    send_text("0x1.8p-1075");
    send_text("-0x1.fffffffffffffp1023");
    send_text("0x1p1024");
    send_text("0x1p99999999");
    send_text("0x1p-99999999");
    send_text("0x.p1");
    send_text("0x.8");
    send_text("0x1p");
    send_text("0x1p-");
    send_text("0x1p 5");
    send_text("nan");
    send_text("0xN");
    send_text("123.5");
    send_text("0x");
    send_text("x");
    send_text("0x1 2");
    s.delete();
    s.push_back("0");
    s.push_back("x");
    s.push_back(8'h00);
    send_bytes(s);
    // mantissa too long for a double, overflows to infinity
    s.delete();
    s.push_back("0");
    s.push_back("x");
    repeat (270) s.push_back("f");
    send_bytes(s);
    drain();

    // random phases with different idling
    run_random(150);
    drain();
    send_idle_pct = 67;
    run_random(100);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 67;
    run_random(100);
    drain();
    send_idle_pct = 33;
    recv_stall_pct = 33;
    run_random(100);
    drain();
    // long receiver hold-off while strings keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    run_random(100);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_hex_float_string_parser passed");
    end else begin
      $display("tb_hex_float_string_parser failed");
    end
    $finish;
  end

endmodule
